### rtl/core/drs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Disk request scheduler package
// Shared payload types, policy codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam logic [2:0] ALG_FCFS  = 3'd0;
    localparam logic [2:0] ALG_SSTF  = 3'd1;
    localparam logic [2:0] ALG_SCAN  = 3'd2;
    localparam logic [2:0] ALG_CSCAN = 3'd3;
    localparam logic [2:0] ALG_LOOK  = 3'd4;
    localparam logic [2:0] ALG_CLOOK = 3'd5;

    localparam logic [1:0] REG_ALGORITHM      = 2'd0;
    localparam logic [1:0] REG_CYLINDER_COUNT = 2'd1;
    localparam logic [1:0] REG_START_HEAD     = 2'd2;
    localparam logic [1:0] REG_PREVIOUS_HEAD  = 2'd3;

    typedef struct packed {
        logic [15:0] track;
        logic        last_request;
    } req_t;

    typedef struct packed {
        logic [15:0] position;
        logic [15:0] move_distance;
        logic [21:0] total_movement;
        logic        dropped;
        logic        last_result;
    } res_t;

    // Ordering key used while walking the stored requests.
    typedef enum logic [1:0] {
        KEY_INDEX = 2'd0,
        KEY_SSTF  = 2'd1,
        KEY_MIN   = 2'd2,
        KEY_MAX   = 2'd3
    } key_mode_t;

    typedef enum logic [1:0] {
        GRP_ALL   = 2'd0,
        GRP_LOWER = 2'd1,
        GRP_UPPER = 2'd2
    } group_t;

    typedef struct packed {
        logic      load;
        logic      start;
        logic      scan_start;
        logic      visit_best;
        logic      visit_stop;
        logic      flush;
        key_mode_t mode;
        group_t    group;
        logic      stop_high;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic out_free;
    } status_t;

endpackage : drs_pkg
`default_nettype wire

### rtl/core/drs_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Disk request scheduler datapath
// Request store, served marks, one-entry-per-cycle search, head tracking and
// the pending/output result registers.
// ----------------------------------------------------------------------------
module drs_datapath #(
    parameter int MAX_REQUESTS = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire drs_pkg::cmd_t   cmd,
    output drs_pkg::status_t     status,
    input  wire logic [15:0]     track,
    input  wire logic [15:0]     start_head,
    input  wire logic [15:0]     top_stop,
    output drs_pkg::res_t        res,
    output logic                 res_valid,
    input  wire logic            res_ready
);

    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    logic [15:0]             mem [MAX_REQUESTS];
    logic [CNT_W-1:0]        count_reg;
    logic                    overflow_reg;
    logic [MAX_REQUESTS-1:0] served_reg;
    logic [15:0]             head_reg;
    logic [21:0]             sum_reg;
    logic                    active_reg;
    logic [IDX_W-1:0]        addr_reg;
    logic                    rd_v_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [15:0]             rd_data_reg;
    logic                    found_reg;
    logic [15:0]             best_key_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [15:0]             best_val_reg;
    logic [15:0]             pend_pos_reg;
    logic [15:0]             pend_dist_reg;
    logic [21:0]             pend_sum_reg;
    logic                    pend_v_reg;
    drs_pkg::res_t           out_reg;
    logic                    out_v_reg;

    logic        has_room;
    logic        in_group;
    logic [15:0] key;
    logic        eligible;
    logic        better;
    logic        visit;
    logic [15:0] vpos;
    logic [15:0] vdist;
    logic [21:0] vsum;

    assign has_room = (count_reg < CNT_W'(MAX_REQUESTS));

    always_comb
    begin
        case (cmd.group)
            drs_pkg::GRP_LOWER: in_group = (rd_data_reg <= start_head);
            drs_pkg::GRP_UPPER: in_group = (rd_data_reg > start_head);
            default:            in_group = 1'b1;
        endcase
        case (cmd.mode)
            drs_pkg::KEY_SSTF:
                key = (rd_data_reg >= head_reg) ? rd_data_reg - head_reg
                                                : head_reg - rd_data_reg;
            drs_pkg::KEY_MIN: key = rd_data_reg;
            drs_pkg::KEY_MAX: key = ~rd_data_reg;
            default:          key = 16'(rd_idx_reg);
        endcase
    end

    assign eligible = rd_v_reg && !served_reg[rd_idx_reg] && in_group;
    assign better   = eligible && (!found_reg || (key < best_key_reg));

    assign visit = cmd.visit_best || cmd.visit_stop;
    assign vpos  = cmd.visit_stop ? (cmd.stop_high ? top_stop : 16'd0) : best_val_reg;
    assign vdist = (vpos >= head_reg) ? vpos - head_reg : head_reg - vpos;
    assign vsum  = sum_reg + 22'(vdist);

    // Request store: written on load, read one address per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.load && has_room)
        begin
            mem[count_reg[IDX_W-1:0]] <= track;
        end
        rd_data_reg <= mem[addr_reg];
        rd_idx_reg  <= addr_reg;
        if (better)
        begin
            best_key_reg <= key;
            best_idx_reg <= rd_idx_reg;
            best_val_reg <= rd_data_reg;
        end
        if (visit)
        begin
            pend_pos_reg  <= vpos;
            pend_dist_reg <= vdist;
            pend_sum_reg  <= vsum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            served_reg   <= '0;
            head_reg     <= '0;
            sum_reg      <= '0;
            active_reg   <= 1'b0;
            addr_reg     <= '0;
            rd_v_reg     <= 1'b0;
            found_reg    <= 1'b0;
            pend_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
            out_reg      <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (has_room)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end

            rd_v_reg <= active_reg;
            if (cmd.scan_start)
            begin
                active_reg <= 1'b1;
                addr_reg   <= '0;
                found_reg  <= 1'b0;
            end
            else
            begin
                if (active_reg)
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if ((CNT_W'(addr_reg) + 1'b1) >= count_reg)
                    begin
                        active_reg <= 1'b0;
                    end
                end
                if (better)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (cmd.start)
            begin
                served_reg <= '0;
                head_reg   <= start_head;
                sum_reg    <= '0;
                pend_v_reg <= 1'b0;
            end

            // A visit pushes the previous pending result out; the flush pushes
            // the last one with last_result set.
            if (visit && pend_v_reg)
            begin
                out_reg   <= '{pend_pos_reg, pend_dist_reg, pend_sum_reg,
                               overflow_reg, 1'b0};
                out_v_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                out_reg   <= '{pend_pos_reg, pend_dist_reg, pend_sum_reg,
                               overflow_reg, 1'b1};
                out_v_reg <= pend_v_reg;
            end
            else if (out_v_reg && res_ready)
            begin
                out_v_reg <= 1'b0;
            end

            if (visit)
            begin
                if (cmd.visit_best)
                begin
                    served_reg[best_idx_reg] <= 1'b1;
                end
                head_reg   <= vpos;
                sum_reg    <= vsum;
                pend_v_reg <= 1'b1;
            end

            if (cmd.flush)
            begin
                pend_v_reg   <= 1'b0;
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
        end
    end

    assign status.scan_done = !active_reg && !rd_v_reg;
    assign status.found     = found_reg;
    assign status.out_free  = !out_v_reg || res_ready;

    assign res       = out_reg;
    assign res_valid = out_v_reg;

endmodule : drs_datapath
`default_nettype wire

### rtl/core/drs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Disk request scheduler controller
// Sequences loading, search passes, end stops and the final flush.
// ----------------------------------------------------------------------------
module drs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire logic             last_request,
    input  wire logic [2:0]       algorithm,
    input  wire logic             dir_up,
    input  wire drs_pkg::status_t status,
    output drs_pkg::cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_PICK  = 5'b00100,
        ST_STOP  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   phase2_reg, phase2_next;
    logic   hit_reg, hit_next;

    logic sweep;
    logic wrap;
    logic stops;
    logic accept;

    assign sweep  = (algorithm >= drs_pkg::ALG_SCAN) && (algorithm <= drs_pkg::ALG_CLOOK);
    assign wrap   = (algorithm == drs_pkg::ALG_CSCAN) || (algorithm == drs_pkg::ALG_CLOOK);
    assign stops  = (algorithm == drs_pkg::ALG_SCAN) || (algorithm == drs_pkg::ALG_CSCAN);
    assign accept = req_valid && req_ready;

    always_comb
    begin
        state_next  = state_reg;
        phase2_next = phase2_reg;
        hit_next    = hit_reg;
        req_ready   = 1'b0;
        cmd         = '0;
        cmd.stop_high = dir_up;

        // Search key and group for the current pass.
        if (algorithm == drs_pkg::ALG_SSTF)
        begin
            cmd.mode  = drs_pkg::KEY_SSTF;
            cmd.group = drs_pkg::GRP_ALL;
        end
        else if (sweep)
        begin
            if (dir_up)
            begin
                cmd.group = phase2_reg ? drs_pkg::GRP_LOWER : drs_pkg::GRP_UPPER;
                cmd.mode  = (!phase2_reg || wrap) ? drs_pkg::KEY_MIN : drs_pkg::KEY_MAX;
            end
            else
            begin
                cmd.group = phase2_reg ? drs_pkg::GRP_UPPER : drs_pkg::GRP_LOWER;
                cmd.mode  = (!phase2_reg || wrap) ? drs_pkg::KEY_MAX : drs_pkg::KEY_MIN;
            end
        end
        else
        begin
            cmd.mode  = drs_pkg::KEY_INDEX;
            cmd.group = drs_pkg::GRP_ALL;
        end

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (last_request)
                    begin
                        cmd.start      = 1'b1;
                        cmd.scan_start = 1'b1;
                        phase2_next    = 1'b0;
                        hit_next       = 1'b0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (status.found)
                begin
                    if (status.out_free)
                    begin
                        cmd.visit_best = 1'b1;
                        cmd.scan_start = 1'b1;
                        hit_next       = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
                else if (sweep && !phase2_reg)
                begin
                    if (stops && hit_reg)
                    begin
                        state_next = ST_STOP;
                    end
                    else
                    begin
                        phase2_next    = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_STOP:
            begin
                if (status.out_free)
                begin
                    cmd.visit_stop = 1'b1;
                    cmd.scan_start = 1'b1;
                    phase2_next    = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase2_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase2_reg <= phase2_next;
            hit_reg    <= hit_next;
        end
    end

endmodule : drs_ctrl
`default_nettype wire

### rtl/core/disk_request_scheduler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Disk request scheduler core
// Collects a batch of track requests and emits their service order under
// FCFS, SSTF, SCAN, C-SCAN, LOOK or C-LOOK.
// ----------------------------------------------------------------------------
// Requests are taken one per cycle while the block is idle and held in a
// store of MAX_REQUESTS entries; extras are discarded and every result of
// that batch carries dropped. The request marked last_request starts the
// schedule. Each visited position is found by one pass over the stored
// requests, reading one entry of the store per cycle; SCAN and C-SCAN add
// one short step for the end stop. No new request is taken until the
// schedule is finished, though the final result may still wait in the
// output register while the next batch loads. Configuration must be
// written over the APB-style port only while idle; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
module disk_request_scheduler_core #(
    parameter int MAX_REQUESTS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire drs_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_ready,
    output drs_pkg::res_t      res
);

    logic [2:0]  algorithm_reg;
    logic [16:0] cylinder_count_reg;
    logic [15:0] start_head_reg;
    logic [15:0] previous_head_reg;

    logic              wr_en;
    logic [15:0]       top_stop;
    logic [15:0]       track_clamped;
    logic              dir_up;
    drs_pkg::cmd_t     cmd;
    drs_pkg::status_t  status;

    // Register writes complete in the access phase; pready is tied high.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            algorithm_reg      <= drs_pkg::ALG_FCFS;
            cylinder_count_reg <= 17'h10000;
            start_head_reg     <= '0;
            previous_head_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                drs_pkg::REG_ALGORITHM:      algorithm_reg      <= pwdata[2:0];
                drs_pkg::REG_CYLINDER_COUNT: cylinder_count_reg <= pwdata[16:0];
                drs_pkg::REG_START_HEAD:     start_head_reg     <= pwdata[15:0];
                drs_pkg::REG_PREVIOUS_HEAD:  previous_head_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            drs_pkg::REG_ALGORITHM:      prdata = {29'd0, algorithm_reg};
            drs_pkg::REG_CYLINDER_COUNT: prdata = {15'd0, cylinder_count_reg};
            drs_pkg::REG_START_HEAD:     prdata = {16'd0, start_head_reg};
            drs_pkg::REG_PREVIOUS_HEAD:  prdata = {16'd0, previous_head_reg};
            default:                     prdata = '0;
        endcase
    end

    // Top end stop: a count of zero acts as one, anything above 65536 as 65536.
    always_comb
    begin
        if (cylinder_count_reg == 17'd0)
        begin
            top_stop = 16'd0;
        end
        else if (cylinder_count_reg[16])
        begin
            top_stop = 16'hFFFF;
        end
        else
        begin
            top_stop = cylinder_count_reg[15:0] - 16'd1;
        end
    end

    assign track_clamped = (req.track > top_stop) ? top_stop : req.track;

    // The first sweep goes up when the head is at or above its prior position.
    assign dir_up = (start_head_reg >= previous_head_reg);

    drs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .last_request (req.last_request),
        .algorithm    (algorithm_reg),
        .dir_up       (dir_up),
        .status       (status),
        .cmd          (cmd)
    );

    drs_datapath #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .track      (track_clamped),
        .start_head (start_head_reg),
        .top_stop   (top_stop),
        .res        (res),
        .res_valid  (res_valid),
        .res_ready  (res_ready)
    );

endmodule : disk_request_scheduler_core
`default_nettype wire

### rtl/core/drs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Disk request scheduler checker
// Port-level properties of the scheduler core, bound to the top level.
// ----------------------------------------------------------------------------
module drs_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          pready,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire drs_pkg::req_t req,
    input wire logic          res_valid,
    input wire logic          res_ready,
    input wire drs_pkg::res_t res
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // The running total always includes the latest move.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.total_movement >= 22'(res.move_distance)))
        else $error("total movement below move distance");

    // A request that does not close the batch leaves the block ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !req.last_request |=> req_ready)
        else $error("not ready after a non-final request");

    // The configuration port never inserts wait states.
    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("configuration port stalled");

endmodule : drs_checker

bind disk_request_scheduler_core drs_checker u_drs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
`default_nettype wire
